// ----- design/etc_pkg.sv -----
// ----------------------------------------------------------------------------
// Elevator travel controller package
// Shared widths, register indexes, reset values and bundle types.
// ----------------------------------------------------------------------------
package etc_pkg;

   localparam int BTN_MAX   = 8;
   localparam int FLOOR_W   = 4;
   localparam int BTN_IDX_W = 3;
   localparam int TPF_W     = 12;
   localparam int DEB_W     = 6;
   localparam int BLINK_W   = 10;
   localparam int STABLE_W  = 7;
   localparam int PROG_W    = 3;
   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 2;

   localparam logic [TPF_W-1:0]   TPF_RESET   = 12'd800;
   localparam logic [DEB_W-1:0]   DEB_RESET   = 6'd30;
   localparam logic [BLINK_W-1:0] BLINK_RESET = 10'd400;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICKS_PER_FLOOR = 2'd0,
      CSR_DEBOUNCE_TICKS  = 2'd1,
      CSR_BLINK_TICKS     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TPF_W-1:0]   ticks_per_floor;
      logic [DEB_W-1:0]   debounce_ticks;
      logic [BLINK_W-1:0] blink_ticks;
   } etc_cfg_type;

   typedef struct packed {
      logic [BTN_MAX-1:0] leds;
      logic               moving;
      logic [FLOOR_W-1:0] current_floor;
      logic [FLOOR_W-1:0] target_floor;
      logic [FLOOR_W-1:0] shown_floor;
      logic               arrived;
   } etc_rsp_type;

endpackage

// ----- design/elevator_travel_controller.sv -----
// An accepted transaction's result is registered in the head or skid entry.
// Throughput: one transaction per cycle while req_stall is low.
// A two-entry output stage lets input run while one result waits on rsp_stall.
// Reset: synchronous; clears car, debounce and LED state, car rests at floor 1,
// and restores ticks_per_floor 800, debounce_ticks 30, blink_ticks 400.
// ----------------------------------------------------------------------------
// Elevator travel controller
// Debounce lanes per button, travel/LED core and a two-entry result stage.
// ----------------------------------------------------------------------------
module elevator_travel_controller
   import etc_pkg::*;
#(
   parameter int FLOORS = 8
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BTN_MAX-1:0]   req_buttons,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BTN_MAX-1:0]   rsp_leds,
   output logic                 rsp_moving,
   output logic [FLOOR_W-1:0]   rsp_current_floor,
   output logic [FLOOR_W-1:0]   rsp_target_floor,
   output logic [FLOOR_W-1:0]   rsp_shown_floor,
   output logic                 rsp_arrived,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int LANES = (FLOORS < BTN_MAX) ? FLOORS : BTN_MAX;

   etc_cfg_type        cfg_ff, cfg_in;
   etc_rsp_type        out_ff, out_in;
   etc_rsp_type        skid_ff, skid_in;
   logic               out_valid_ff, out_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   etc_rsp_type        rsp_next;
   logic [BTN_MAX-1:0] hit;
   logic [BTN_MAX-1:0] sample_en;
   logic               accept;
   logic               take;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;
   assign take      = out_valid_ff & ~rsp_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TICKS_PER_FLOOR: cfg_in.ticks_per_floor = csr_wdata[TPF_W-1:0];
            CSR_DEBOUNCE_TICKS:  cfg_in.debounce_ticks  = csr_wdata[DEB_W-1:0];
            CSR_BLINK_TICKS:     cfg_in.blink_ticks     = csr_wdata[BLINK_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < BTN_MAX; gi++) begin : g_lane
         if (gi < LANES) begin : g_on
            etc_lane u_lane (
               .clock          (clock),
               .reset          (reset),
               .step           (accept),
               .sample_en      (sample_en[gi]),
               .level          (req_buttons[gi]),
               .debounce_ticks (cfg_ff.debounce_ticks),
               .hit            (hit[gi])
            );
         end else begin : g_off
            // floors beyond the car's range never raise a request
            assign hit[gi] = 1'b0;
         end
      end
   endgenerate

   etc_travel u_travel (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .cfg       (cfg_ff),
      .hit       (hit),
      .sample_en (sample_en),
      .rsp       (rsp_next)
   );

   // two-entry result stage: the skid entry fills only while the head is held
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_in       = rsp_next;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = rsp_next;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_floor <= TPF_RESET;
         cfg_ff.debounce_ticks  <= DEB_RESET;
         cfg_ff.blink_ticks     <= BLINK_RESET;
         out_valid_ff           <= 1'b0;
         skid_valid_ff          <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_leds          = out_ff.leds;
   assign rsp_moving        = out_ff.moving;
   assign rsp_current_floor = out_ff.current_floor;
   assign rsp_target_floor  = out_ff.target_floor;
   assign rsp_shown_floor   = out_ff.shown_floor;
   assign rsp_arrived       = out_ff.arrived;

`ifndef SYNTH
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with an empty head");
`endif

endmodule

// ----- design/etc_lane.sv -----
// ----------------------------------------------------------------------------
// Button debounce lane
// Tracks one button level and its saturating stable-time count.
// ----------------------------------------------------------------------------
module etc_lane
   import etc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             sample_en,
   input  logic             level,
   input  logic [DEB_W-1:0] debounce_ticks,
   output logic             hit
);

   logic                level_ff, level_in;
   logic [STABLE_W-1:0] count_ff, count_in;
   logic [STABLE_W-1:0] count_inc;
   logic                changed;

   always_comb begin
      count_inc = (count_ff == {STABLE_W{1'b1}}) ? count_ff : count_ff + 1'b1;
      changed   = level != level_ff;
      // a changed level can never hit this tick, and restarts the count when sampled
      hit       = level & ~changed & (count_inc > {1'b0, debounce_ticks});
      count_in  = (sample_en && changed) ? '0 : count_inc;
      level_in  = sample_en ? level : level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         count_ff <= '0;
      end else if (step) begin
         level_ff <= level_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- design/etc_travel.sv -----
// ----------------------------------------------------------------------------
// Elevator travel core
// Merges lane hits into a target, runs travel timing and drives the LEDs.
// ----------------------------------------------------------------------------
module etc_travel
   import etc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  etc_cfg_type        cfg,
   input  logic [BTN_MAX-1:0] hit,
   output logic [BTN_MAX-1:0] sample_en,
   output etc_rsp_type        rsp
);

   localparam int ELAPSED_W = 15;

   logic                 moving_ff, moving_in;
   logic [FLOOR_W-1:0]   rest_ff, rest_in;
   logic [FLOOR_W-1:0]   goal_ff, goal_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [FLOOR_W-1:0]   prev_ff, prev_in;
   logic                 fon_ff, fon_in;
   logic [BLINK_W-1:0]   fcnt_ff, fcnt_in;
   logic                 gon_ff, gon_in;
   logic [BLINK_W-1:0]   gcnt_ff, gcnt_in;
   logic [BTN_MAX-1:0]   led_ff, led_in;

   logic                 found;
   logic                 blocked;
   logic [BTN_IDX_W-1:0] idx;
   logic                 start;
   logic                 active;
   logic                 arrive;
   logic [PROG_W-1:0]    prog;
   logic [ELAPSED_W:0]   tpf_wide;
   logic [ELAPSED_W:0]   span_ticks;
   logic [FLOOR_W-1:0]   floor_gap;
   logic [FLOOR_W-1:0]   shown;

   function automatic logic [BTN_MAX-1:0] led_put(input logic [BTN_MAX-1:0] led,
                                                  input logic [FLOOR_W-1:0] floor,
                                                  input logic on);
      logic [BTN_MAX-1:0] res;
      res = led;
      for (int b = 0; b < BTN_MAX; b++) begin
         if (floor == FLOOR_W'(b + 1)) res[b] = on;
      end
      return res;
   endfunction

   // lowest-numbered hit wins; lanes above it are not sampled
   always_comb begin
      found   = |hit;
      idx     = '0;
      blocked = 1'b0;
      for (int i = BTN_MAX - 1; i >= 0; i--) begin
         if (hit[i]) idx = BTN_IDX_W'(i);
      end
      for (int i = 0; i < BTN_MAX; i++) begin
         sample_en[i] = ~moving_ff & ~blocked;
         blocked      = blocked | hit[i];
      end
   end

   always_comb begin
      start      = ~moving_ff & found;
      active     = moving_ff | start;
      moving_in  = active;
      rest_in    = rest_ff;
      goal_in    = start ? FLOOR_W'(idx) + 4'd1 : goal_ff;
      prev_in    = prev_ff;
      fon_in     = fon_ff;
      gon_in     = gon_ff;
      led_in     = led_ff;
      fcnt_in    = (fcnt_ff == {BLINK_W{1'b1}}) ? fcnt_ff : fcnt_ff + 1'b1;
      gcnt_in    = (gcnt_ff == {BLINK_W{1'b1}}) ? gcnt_ff : gcnt_ff + 1'b1;
      elapsed_in = (elapsed_ff == {ELAPSED_W{1'b1}}) ? elapsed_ff : elapsed_ff + 1'b1;
      shown      = '0;
      arrive     = 1'b0;

      if (start) begin
         led_in     = led_put('0, goal_in, 1'b1);
         gon_in     = 1'b1;
         gcnt_in    = '0;
         elapsed_in = '0;
      end

      floor_gap  = (goal_in > rest_ff) ? goal_in - rest_ff : rest_ff - goal_in;
      tpf_wide   = {{(ELAPSED_W + 1 - TPF_W){1'b0}}, cfg.ticks_per_floor};
      span_ticks = (ELAPSED_W + 1)'(floor_gap) * tpf_wide;

      // whole floors covered so far, from the current travel time per floor
      prog = '0;
      for (int k = 1; k < (1 << PROG_W); k++) begin
         if ({1'b0, elapsed_in} >= (ELAPSED_W + 1)'(k) * tpf_wide) prog = PROG_W'(k);
      end

      if (active) begin
         if (floor_gap == '0 || cfg.ticks_per_floor == '0 ||
             {1'b0, elapsed_in} >= span_ticks || elapsed_in == {ELAPSED_W{1'b1}}) begin
            arrive    = 1'b1;
            rest_in   = goal_in;
            moving_in = 1'b0;
            led_in    = led_put('0, goal_in, 1'b1);
            fon_in    = 1'b0;
            fcnt_in   = '0;
         end else begin
            shown = (goal_in > rest_ff) ? rest_ff + FLOOR_W'(prog)
                                        : rest_ff - FLOOR_W'(prog);
            if (shown != prev_ff) begin
               led_in  = led_put(led_in, prev_ff, 1'b0);
               prev_in = shown;
               fon_in  = 1'b0;
               fcnt_in = '0;
            end
            if (fcnt_in >= cfg.blink_ticks) begin
               fcnt_in = '0;
               fon_in  = ~fon_in;
               led_in  = led_put(led_in, shown, fon_in);
            end
            if (gcnt_in >= cfg.blink_ticks) begin
               gcnt_in = '0;
               gon_in  = ~gon_in;
               led_in  = led_put(led_in, goal_in, gon_in);
            end
         end
      end

      rsp.leds          = led_in;
      rsp.moving        = moving_in;
      rsp.current_floor = rest_in;
      rsp.target_floor  = goal_in;
      rsp.shown_floor   = moving_in ? shown : '0;
      rsp.arrived       = arrive;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         moving_ff  <= 1'b0;
         rest_ff    <= FLOOR_W'(1);
         goal_ff    <= '0;
         elapsed_ff <= '0;
         prev_ff    <= '0;
         fon_ff     <= 1'b0;
         fcnt_ff    <= '0;
         gon_ff     <= 1'b0;
         gcnt_ff    <= '0;
         led_ff     <= '0;
      end else if (step) begin
         moving_ff  <= moving_in;
         rest_ff    <= rest_in;
         goal_ff    <= goal_in;
         elapsed_ff <= elapsed_in;
         prev_ff    <= prev_in;
         fon_ff     <= fon_in;
         fcnt_ff    <= fcnt_in;
         gon_ff     <= gon_in;
         gcnt_ff    <= gcnt_in;
         led_ff     <= led_in;
      end
   end

`ifndef SYNTH
   a_arrive_rests: assert property (@(posedge clock) disable iff (reset)
      (step && arrive) |=> (!moving_ff && rest_ff == goal_ff))
      else $error("arrival did not settle the car at the target");

   a_moving_has_distance: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (goal_ff != rest_ff && goal_ff != '0))
      else $error("travelling with no distance to cover");

   a_travel_unsaturated: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (elapsed_ff != {ELAPSED_W{1'b1}}))
      else $error("travel time saturated while still moving");
`endif

endmodule
